@@ src/aabb_contact_generator_defines.svh @@
// Assertion macros for the files that check their own logic.
`ifndef AABB_CONTACT_GENERATOR_DEFINES_SVH
`define AABB_CONTACT_GENERATOR_DEFINES_SVH

// When the condition holds at a clock edge, the consequence holds at the same edge.
`define ACG_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("aabb_contact_generator: same-cycle check failed");

// When the condition holds at a clock edge, the consequence holds at the next edge.
`define ACG_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("aabb_contact_generator: next-cycle check failed");

`endif

@@ src/aabbcg_pkg.sv @@
`default_nettype none

package aabbcg_pkg;

    // Field widths of one box pair and one contact.
    localparam int CENTER_W = 24;
    localparam int HALF_W   = 22;
    localparam int EXT_W    = 25;
    localparam int PEN_W    = 23;
    localparam int AXIS_W   = 2;

    // Packed stream widths, filled up to whole bytes.
    localparam int IN_BITS  = 6 * CENTER_W + 6 * HALF_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = PEN_W + AXIS_W + 1 + 3 * CENTER_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Contact normal axis codes.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Per-axis result handed from an axis lane to the selection stage.
    typedef struct packed {
        logic                overlap;
        logic                below;
        logic [PEN_W-1:0]    depth;
        logic [CENTER_W-1:0] mid;
    } t_axis_res;

endpackage

`default_nettype wire

@@ src/aabbcg_axis.sv @@
`default_nettype none

// One axis lane: three register stages from centers and half extents to the
// interval overlap flag, the overlap depth and the center midpoint.
module aabbcg_axis (
    input  wire                                  i_clk,
    input  wire                                  i_en,
    input  wire  [aabbcg_pkg::CENTER_W-1:0]      i_a_center,
    input  wire  [aabbcg_pkg::HALF_W-1:0]        i_a_half,
    input  wire  [aabbcg_pkg::CENTER_W-1:0]      i_b_center,
    input  wire  [aabbcg_pkg::HALF_W-1:0]        i_b_half,
    output aabbcg_pkg::t_axis_res                o_res
);
    import aabbcg_pkg::*;

    logic signed [EXT_W-1:0]    ac_e, bc_e, ah_e, bh_e, sum_e;
    logic signed [EXT_W-1:0]    r_amin, r_amax, r_bmin, r_bmax;
    logic signed [EXT_W-1:0]    r_hi, r_lo;
    logic signed [EXT_W:0]      diff_e;
    logic                       r_below1, r_below2, r_below3;
    logic                       r_ovl2, r_ovl3;
    logic [CENTER_W-1:0]        r_mid1, r_mid2, r_mid3;
    logic [PEN_W-1:0]           r_depth3;

    // Sign- and zero-extend the operands to the corner width.
    always_comb begin
        ac_e  = {i_a_center[CENTER_W-1], i_a_center};
        bc_e  = {i_b_center[CENTER_W-1], i_b_center};
        ah_e  = {{(EXT_W-HALF_W){1'b0}}, i_a_half};
        bh_e  = {{(EXT_W-HALF_W){1'b0}}, i_b_half};
        sum_e = ac_e + bc_e;
    end

    // Stage 1: box corners, center order and midpoint.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_amin   <= ac_e - ah_e;
            r_amax   <= ac_e + ah_e;
            r_bmin   <= bc_e - bh_e;
            r_bmax   <= bc_e + bh_e;
            r_below1 <= (bc_e < ac_e);
            r_mid1   <= sum_e[EXT_W-1:1];
        end
    end

    // Stage 2: overlap test, touching counts, and the inner interval bounds.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovl2   <= (r_amax >= r_bmin) && (r_amin <= r_bmax);
            r_hi     <= (r_amax < r_bmax) ? r_amax : r_bmax;
            r_lo     <= (r_amin > r_bmin) ? r_amin : r_bmin;
            r_below2 <= r_below1;
            r_mid2   <= r_mid1;
        end
    end

    assign diff_e = {r_hi[EXT_W-1], r_hi} - {r_lo[EXT_W-1], r_lo};

    // Stage 3: overlap depth; it fits the depth width whenever the axis overlaps.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_depth3 <= diff_e[PEN_W-1:0];
            r_ovl3   <= r_ovl2;
            r_below3 <= r_below2;
            r_mid3   <= r_mid2;
        end
    end

    always_comb begin
        o_res.overlap = r_ovl3;
        o_res.below   = r_below3;
        o_res.depth   = r_depth3;
        o_res.mid     = r_mid3;
    end

endmodule

`default_nettype wire

@@ src/aabb_contact_generator.sv @@
`default_nettype none
`include "aabb_contact_generator_defines.svh"

// Box pair contact generator.
// The slave channel takes one pair of axis-aligned boxes per item on s_axis_tdata:
// two centers and two half extents per axis, as signed Q15.8 and unsigned Q14.8.
// The master channel returns one contact per item: m_axis_tuser carries the hit flag
// and m_axis_tdata the penetration depth, the normal axis and sign, and the contact
// point (center midpoint). On a miss all tdata fields are zero.
// An accepted input reaches the master side through three stages in each axis lane
// plus the selection stage, which is the output register. One item enters per
// cycle when the receiver keeps up.
// The pipeline advances whenever the output register is empty or being drained.
// When the receiver stalls, the pipeline holds and an item already offered at the
// input is caught in a one-entry skid register; s_axis_tready drops only while that
// register is full, so tready never depends combinationally on m_axis_tready.
// Reset clears the valid bits of the skid register and of every stage; no result
// is lost or repeated across a stall.
module aabb_contact_generator (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // a_center_x, a_center_y, a_center_z, a_half_x, a_half_y, a_half_z,
    // b_center_x, b_center_y, b_center_z, b_half_x, b_half_y, b_half_z, zero fill
    input  wire  [aabbcg_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // penetration, normal_axis, normal_negative, contact_x, contact_y, contact_z,
    // zero fill
    output logic [aabbcg_pkg::OUT_W-1:0]  m_axis_tdata,
    // hit
    output logic                          m_axis_tuser
);
    import aabbcg_pkg::*;

    logic                  r_skid_v;
    logic [IN_BITS-1:0]    r_skid_data;
    logic [IN_BITS-1:0]    src_data;
    logic                  src_v;
    logic                  in_acc;
    logic                  en;
    logic                  r_v1, r_v2, r_v3, r_v4;

    t_axis_res             res_x, res_y, res_z;
    logic                  all_hit;
    logic [PEN_W-1:0]      best01, best;
    logic [AXIS_W-1:0]     axis01, axis;
    logic                  below01, below;

    logic                  r_hit;
    logic [PEN_W-1:0]      r_pen;
    logic [AXIS_W-1:0]     r_axis;
    logic                  r_neg;
    logic [CENTER_W-1:0]   r_cx, r_cy, r_cz;

    // Handshake and pipeline advance.
    assign s_axis_tready = !r_skid_v;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign en            = !r_v4 || m_axis_tready;
    assign src_v         = r_skid_v || in_acc;
    assign src_data      = r_skid_v ? r_skid_data : s_axis_tdata[IN_BITS-1:0];

    // Skid register catches an item accepted while the pipeline is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (en) begin
            r_skid_v <= 1'b0;
        end else if (in_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && in_acc) begin
            r_skid_data <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    // Valid bits travel alongside the lane stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= src_v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Three axis lanes working in parallel.
    aabbcg_axis u_axis_x (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_a_center (src_data[0*CENTER_W +: CENTER_W]),
        .i_a_half   (src_data[3*CENTER_W + 0*HALF_W +: HALF_W]),
        .i_b_center (src_data[3*CENTER_W + 3*HALF_W + 0*CENTER_W +: CENTER_W]),
        .i_b_half   (src_data[6*CENTER_W + 3*HALF_W + 0*HALF_W +: HALF_W]),
        .o_res      (res_x)
    );

    aabbcg_axis u_axis_y (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_a_center (src_data[1*CENTER_W +: CENTER_W]),
        .i_a_half   (src_data[3*CENTER_W + 1*HALF_W +: HALF_W]),
        .i_b_center (src_data[3*CENTER_W + 3*HALF_W + 1*CENTER_W +: CENTER_W]),
        .i_b_half   (src_data[6*CENTER_W + 3*HALF_W + 1*HALF_W +: HALF_W]),
        .o_res      (res_y)
    );

    aabbcg_axis u_axis_z (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_a_center (src_data[2*CENTER_W +: CENTER_W]),
        .i_a_half   (src_data[3*CENTER_W + 2*HALF_W +: HALF_W]),
        .i_b_center (src_data[3*CENTER_W + 3*HALF_W + 2*CENTER_W +: CENTER_W]),
        .i_b_half   (src_data[6*CENTER_W + 3*HALF_W + 2*HALF_W +: HALF_W]),
        .o_res      (res_z)
    );

    // Least-penetration axis; x wins ties over y, and y over z.
    always_comb begin
        all_hit = res_x.overlap && res_y.overlap && res_z.overlap;
        if (res_y.depth < res_x.depth) begin
            best01  = res_y.depth;
            axis01  = AXIS_Y;
            below01 = res_y.below;
        end else begin
            best01  = res_x.depth;
            axis01  = AXIS_X;
            below01 = res_x.below;
        end
        if (res_z.depth < best01) begin
            best  = res_z.depth;
            axis  = AXIS_Z;
            below = res_z.below;
        end else begin
            best  = best01;
            axis  = axis01;
            below = below01;
        end
    end

    // Output register; a miss clears every field but the hit flag.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit  <= all_hit;
            r_pen  <= all_hit ? best : '0;
            r_axis <= all_hit ? axis : AXIS_X;
            r_neg  <= all_hit && below;
            r_cx   <= all_hit ? res_x.mid : '0;
            r_cy   <= all_hit ? res_y.mid : '0;
            r_cz   <= all_hit ? res_z.mid : '0;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, r_cz, r_cy, r_cx, r_neg, r_axis, r_pen};

    // Checks on the block's own logic.
    `ACG_ASSERT_SAME(a_miss_clears, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    `ACG_ASSERT_SAME(a_axis_code, m_axis_tvalid && m_axis_tuser, r_axis != 2'd3)
    `ACG_ASSERT_NEXT(a_skid_drains, r_skid_v && en, !r_skid_v)

endmodule

`default_nettype wire

@@ dv/tb_aabb_contact_generator.sv @@
`timescale 1ns / 1ps

module tb_aabb_contact_generator;
    import aabbcg_pkg::*;

    // Bit positions of the contact fields inside m_axis_tdata.
    localparam int AXIS_LSB = PEN_W;
    localparam int NEG_BIT  = PEN_W + AXIS_W;
    localparam int CX_LSB   = NEG_BIT + 1;
    localparam int CY_LSB   = CX_LSB + CENTER_W;
    localparam int CZ_LSB   = CY_LSB + CENTER_W;

    typedef struct packed {
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic signed [CENTER_W-1:0] cz;
        logic [HALF_W-1:0]          hx;
        logic [HALF_W-1:0]          hy;
        logic [HALF_W-1:0]          hz;
    } t_box;

    typedef struct packed {
        logic                       hit;
        logic [PEN_W-1:0]           pen;
        logic [AXIS_W-1:0]          axis;
        logic                       neg;
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic signed [CENTER_W-1:0] cz;
    } t_contact;

    // Holds the contacts still owed by the block and checks each one as it leaves.
    class contact_scoreboard;
        t_contact pending_contacts[$];
        int       failures;

        // Works out the contact for one box pair with exact integer arithmetic.
        function t_contact predict_contact(t_box a, t_box b);
            t_contact c;
            longint   ac[3], ah[3], bc[3], bh[3], depth[3];
            longint   amin, amax, bmin, bmax, best, mid;
            bit       all_overlap;
            int       k, idx;
            ac = '{longint'(a.cx), longint'(a.cy), longint'(a.cz)};
            bc = '{longint'(b.cx), longint'(b.cy), longint'(b.cz)};
            ah = '{longint'(a.hx), longint'(a.hy), longint'(a.hz)};
            bh = '{longint'(b.hx), longint'(b.hy), longint'(b.hz)};
            all_overlap = 1'b1;
            for (k = 0; k < 3; k++) begin
                amin = ac[k] - ah[k];
                amax = ac[k] + ah[k];
                bmin = bc[k] - bh[k];
                bmax = bc[k] + bh[k];
                // Touching intervals still count as overlapping.
                if (!(amax >= bmin && amin <= bmax)) all_overlap = 1'b0;
                depth[k] = ((amax < bmax) ? amax : bmax) - ((amin > bmin) ? amin : bmin);
            end
            c = '0;
            if (all_overlap) begin
                // Ties go to x first, then y.
                idx = 0;
                best = depth[0];
                c.axis = AXIS_X;
                if (depth[1] < best) begin
                    best = depth[1];
                    idx = 1;
                    c.axis = AXIS_Y;
                end
                if (depth[2] < best) begin
                    best = depth[2];
                    idx = 2;
                    c.axis = AXIS_Z;
                end
                c.hit = 1'b1;
                c.pen = best[PEN_W-1:0];
                c.neg = bc[idx] < ac[idx];
                // The midpoint rounds toward minus infinity.
                mid = (ac[0] + bc[0]) >>> 1;
                c.cx = mid[CENTER_W-1:0];
                mid = (ac[1] + bc[1]) >>> 1;
                c.cy = mid[CENTER_W-1:0];
                mid = (ac[2] + bc[2]) >>> 1;
                c.cz = mid[CENTER_W-1:0];
            end
            return c;
        endfunction

        function void note_pair(t_box a, t_box b);
            pending_contacts.push_back(predict_contact(a, b));
        endfunction

        function void check_contact(logic [OUT_W-1:0] data, logic user);
            t_contact got, want;
            got.hit  = user;
            got.pen  = data[PEN_W-1:0];
            got.axis = data[AXIS_LSB +: AXIS_W];
            got.neg  = data[NEG_BIT];
            got.cx   = data[CX_LSB +: CENTER_W];
            got.cy   = data[CY_LSB +: CENTER_W];
            got.cz   = data[CZ_LSB +: CENTER_W];
            if (pending_contacts.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: contact with none outstanding: hit=%0d pen=%0d axis=%0d",
                             $realtime, got.hit, got.pen, got.axis);
                return;
            end
            want = pending_contacts.pop_front();
            if (got.hit !== want.hit || got.pen !== want.pen || got.axis !== want.axis ||
                got.neg !== want.neg || got.cx !== want.cx || got.cy !== want.cy ||
                got.cz !== want.cz) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: contact mismatch", $realtime);
                    $display("  expected hit=%0d pen=%0d axis=%0d neg=%0d point=(%0d,%0d,%0d)",
                             want.hit, want.pen, want.axis, want.neg, want.cx, want.cy, want.cz);
                    $display("  actual   hit=%0d pen=%0d axis=%0d neg=%0d point=(%0d,%0d,%0d)",
                             got.hit, got.pen, got.axis, got.neg, got.cx, got.cy, got.cz);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;

    // Set while both sides run without any idle cycles.
    bit                calm = 1'b0;
    contact_scoreboard board;

    aabb_contact_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: checks each accepted contact and stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) board.check_contact(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    function automatic t_box make_box(longint cx, longint cy, longint cz,
                                      longint hx, longint hy, longint hz);
        t_box bx;
        bx.cx = cx[CENTER_W-1:0];
        bx.cy = cy[CENTER_W-1:0];
        bx.cz = cz[CENTER_W-1:0];
        bx.hx = hx[HALF_W-1:0];
        bx.hy = hy[HALF_W-1:0];
        bx.hz = hz[HALF_W-1:0];
        return bx;
    endfunction

    // Offers one box pair, after a random number of idle cycles, and waits for acceptance.
    task automatic send_pair(input t_box a, input t_box b);
        int gaps;
        gaps = 0;
        while (!calm && $urandom_range(0, 99) < 33) gaps++;
        if (gaps > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, b.hz, b.hy, b.hx, b.cz, b.cy, b.cx,
                          a.hz, a.hy, a.hx, a.cz, a.cy, a.cx};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_pair(a, b);
    endtask

    task automatic wait_drained();
        while (board.pending_contacts.size() != 0) @(posedge i_clk);
    endtask

    // Sends one random pair: mostly boxes placed near each other, some fully random.
    task automatic send_random_pair();
        longint      ca[3], cb[3], d;
        int unsigned ha[3], hb[3], lim;
        int          kind, k;
        t_box        a, b;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            a = make_box(longint'($urandom()), longint'($urandom()), longint'($urandom()),
                         longint'($urandom()), longint'($urandom()), longint'($urandom()));
            b = make_box(longint'($urandom()), longint'($urandom()), longint'($urandom()),
                         longint'($urandom()), longint'($urandom()), longint'($urandom()));
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: lim = 15;
                4, 5, 6:    lim = 255;
                7, 8:       lim = 65535;
                default:    lim = (1 << HALF_W) - 1;
            endcase
            for (k = 0; k < 3; k++) begin
                ha[k] = $urandom_range(0, lim);
                hb[k] = $urandom_range(0, lim);
                ca[k] = longint'($urandom_range(0, (1 << CENTER_W) - 1)) - (1 << (CENTER_W - 1));
                // A small margin past the sum of the halves gives near misses.
                d = longint'($urandom_range(0, ha[k] + hb[k] + 2));
                if ($urandom_range(0, 1)) d = -d;
                cb[k] = ca[k] + d;
            end
            // Same geometry on every axis makes all three depths tie.
            if (kind >= 88) begin
                for (k = 1; k < 3; k++) begin
                    ha[k] = ha[0];
                    hb[k] = hb[0];
                    cb[k] = ca[k] + (cb[0] - ca[0]);
                end
            end
            a = make_box(ca[0], ca[1], ca[2], ha[0], ha[1], ha[2]);
            b = make_box(cb[0], cb[1], cb[2], hb[0], hb[1], hb[2]);
        end
        send_pair(a, b);
    endtask

    // Stimulus.
    initial begin
        int n;
        longint cmax, cmin, hmax;
        board = new();
        cmax = (1 << (CENTER_W - 1)) - 1;
        cmin = -(1 << (CENTER_W - 1));
        hmax = (1 << HALF_W) - 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Point boxes at the same spot: zero depth on all axes, x wins the tie.
        send_pair(make_box(0, 0, 0, 0, 0, 0), make_box(0, 0, 0, 0, 0, 0));
        // Touching on x, then one step apart on x.
        send_pair(make_box(0, 0, 0, 256, 256, 256), make_box(512, 0, 0, 256, 256, 256));
        send_pair(make_box(0, 0, 0, 256, 256, 256), make_box(513, 0, 0, 256, 256, 256));
        // Separated on y only, then on z only.
        send_pair(make_box(0, 0, 0, 256, 256, 256), make_box(0, -600, 0, 256, 256, 256));
        send_pair(make_box(0, 0, 0, 256, 256, 256), make_box(0, 0, 600, 256, 256, 256));
        // Smallest depth on y, then on z with the second box below.
        send_pair(make_box(0, 0, 0, 1000, 1000, 1000), make_box(100, 900, -200, 500, 500, 500));
        send_pair(make_box(0, 0, 0, 1000, 1000, 1000), make_box(0, 0, -1200, 500, 500, 500));
        // x ties with y while below; y ties with z.
        send_pair(make_box(0, 0, 0, 1000, 1000, 1000), make_box(-800, -800, 0, 500, 500, 500));
        send_pair(make_box(0, 0, 0, 1000, 1000, 1000), make_box(0, 800, -800, 500, 500, 500));
        // Smallest depth on y with the second box below.
        send_pair(make_box(0, 0, 0, 1000, 1000, 1000), make_box(0, -900, 0, 500, 500, 500));
        // Extreme corners and the largest halves.
        send_pair(make_box(cmax, cmax, cmax, hmax, hmax, hmax),
                  make_box(cmin, cmin, cmin, hmax, hmax, hmax));
        send_pair(make_box(cmax, cmax, cmax, hmax, hmax, hmax),
                  make_box(cmax, cmax, cmax, hmax, hmax, hmax));
        send_pair(make_box(cmin, cmin, cmin, hmax, hmax, hmax),
                  make_box(cmin, cmin, cmin, hmax, hmax, hmax));
        // Largest halves touching at the widest overlapping gap; then one step wider on x.
        send_pair(make_box(cmax, cmax, cmax, hmax, hmax, hmax),
                  make_box(1, 1, 1, hmax, hmax, hmax));
        send_pair(make_box(cmax, 0, 0, hmax, hmax, hmax), make_box(0, 0, 0, hmax, hmax, hmax));
        // Odd negative sums for the midpoint.
        send_pair(make_box(-3, -1, 5, 100, 100, 100), make_box(0, 0, -8, 100, 100, 100));
        send_pair(make_box(-1, -1, -1, 10, 10, 10), make_box(-2, -2, -2, 10, 10, 10));
        // Point boxes one step apart on z miss.
        send_pair(make_box(7, 7, 7, 0, 0, 0), make_box(7, 7, 8, 0, 0, 0));
        // One box inside the other.
        send_pair(make_box(0, 0, 0, 10000, 10000, 10000), make_box(300, -40, 5, 10, 12, 11));
        // Alternating bit patterns in the halves.
        send_pair(make_box(0, 0, 0, 'h2AAAAA, 'h155555, 'h2AAAAA),
                  make_box(-5, 6, -7, 'h155555, 'h2AAAAA, 'h155555));

        // Hold off until every contact of the directed part is back.
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (n = 0; n < 1000; n++) begin
            calm = (n >= 500 && n < 650);
            send_random_pair();
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.failures == 0 && board.pending_contacts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
